>>> rtl/nket_pkg.sv
// ----------------------------------------------------------------------------
// nket_pkg
// Shared types and constants of the name keyed entry table: command and
// status codes, and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package nket_pkg;

    localparam int KEY_A_W   = 64;
    localparam int KEY_B_W   = 64;
    localparam int KEY_C_W   = 24;
    localparam int NUM_A_W   = 64;
    localparam int NUM_B_W   = 32;
    localparam int KEY_W     = KEY_A_W + KEY_B_W + KEY_C_W;
    localparam int NUM_W     = NUM_A_W + NUM_B_W;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 4;
    localparam int USED_W    = 5;
    // a listing shows at most this many entries
    localparam int LIST_LIMIT = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LIST   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED   = 3'd0,
        ST_ADDED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_LISTED    = 3'd5,
        ST_EMPTY     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        SLOT_NONE,
        SLOT_HIT,
        SLOT_COUNT
    } slot_sel_t;

    typedef struct packed {
        logic      load_in;     // latch input fields, rewind the scan
        logic      step;        // advance the read pipeline over used entries
        logic      shift;       // write pipeline data one slot down
        logic      shift_init;  // restart the read pipeline after the hit
        logic      upd_number;  // overwrite number of the hit entry
        logic      append;      // write new entry at the end
        logic      dec_count;
        logic      set_res;
        status_t   res_status;
        slot_sel_t res_slot;
        logic      list_read;
        logic      emit_res;
        logic      emit_entry;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic miss;
        logic full;
        logic empty;
        logic shift_done;
        logic list_last;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/name_keyed_entry_table.sv
// ----------------------------------------------------------------------------
// name_keyed_entry_table
// Packed, unsorted table of name/number entries with add-or-change, remove
// and list commands.
// ----------------------------------------------------------------------------
// One command is worked on at a time; s_ready is high only while the block
// waits for a command, and a finished result may still sit in the output
// register while the next command is taken. The search reads one stored entry
// per cycle through the name RAM read port. Remove adds a shift-down pass of
// the entries behind the hit through the same port. List reads and shows
// one entry at a time, at most 16.
// Entry storage comes out of reset undefined and needs no clearing.
module name_keyed_entry_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [nket_pkg::KIND_W-1:0]       s_kind,
    input  logic [nket_pkg::KEY_A_W-1:0]      s_key_word_a,
    input  logic [nket_pkg::KEY_B_W-1:0]      s_key_word_b,
    input  logic [nket_pkg::KEY_C_W-1:0]      s_key_word_c,
    input  logic [nket_pkg::NUM_A_W-1:0]      s_number_word_a,
    input  logic [nket_pkg::NUM_B_W-1:0]      s_number_word_b,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [nket_pkg::STATUS_W-1:0]     m_status,
    output logic [nket_pkg::SLOT_W-1:0]       m_slot,
    output logic [nket_pkg::KEY_A_W-1:0]      m_out_name_a,
    output logic [nket_pkg::KEY_B_W-1:0]      m_out_name_b,
    output logic [nket_pkg::KEY_C_W-1:0]      m_out_name_c,
    output logic [nket_pkg::NUM_A_W-1:0]      m_out_number_a,
    output logic [nket_pkg::NUM_B_W-1:0]      m_out_number_b,
    output logic [nket_pkg::USED_W-1:0]       m_used_count,
    output logic                              m_last_of_run
);

    nket_pkg::cmd_t cmd;
    nket_pkg::sts_t sts;

    nket_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .sts     (sts),
        .cmd     (cmd)
    );

    nket_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_key_word_a    (s_key_word_a),
        .s_key_word_b    (s_key_word_b),
        .s_key_word_c    (s_key_word_c),
        .s_number_word_a (s_number_word_a),
        .s_number_word_b (s_number_word_b),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot          (m_slot),
        .m_out_name_a    (m_out_name_a),
        .m_out_name_b    (m_out_name_b),
        .m_out_name_c    (m_out_name_c),
        .m_out_number_a  (m_out_number_a),
        .m_out_number_b  (m_out_number_b),
        .m_used_count    (m_used_count),
        .m_last_of_run   (m_last_of_run)
    );

endmodule

>>> rtl/nket_ram.sv
// ----------------------------------------------------------------------------
// nket_ram
// Generic single write, single read RAM with registered read data that holds
// while the read is not enabled.
// ----------------------------------------------------------------------------
module nket_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/nket_datapath.sv
// ----------------------------------------------------------------------------
// nket_datapath
// Entry storage, entry count, the read/compare pipeline used for search and
// shift, and the result register.
// ----------------------------------------------------------------------------
module nket_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  nket_pkg::cmd_t                    cmd,
    output nket_pkg::sts_t                    sts,
    input  logic [nket_pkg::KEY_A_W-1:0]      s_key_word_a,
    input  logic [nket_pkg::KEY_B_W-1:0]      s_key_word_b,
    input  logic [nket_pkg::KEY_C_W-1:0]      s_key_word_c,
    input  logic [nket_pkg::NUM_A_W-1:0]      s_number_word_a,
    input  logic [nket_pkg::NUM_B_W-1:0]      s_number_word_b,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [nket_pkg::STATUS_W-1:0]     m_status,
    output logic [nket_pkg::SLOT_W-1:0]       m_slot,
    output logic [nket_pkg::KEY_A_W-1:0]      m_out_name_a,
    output logic [nket_pkg::KEY_B_W-1:0]      m_out_name_b,
    output logic [nket_pkg::KEY_C_W-1:0]      m_out_name_c,
    output logic [nket_pkg::NUM_A_W-1:0]      m_out_number_a,
    output logic [nket_pkg::NUM_B_W-1:0]      m_out_number_b,
    output logic [nket_pkg::USED_W-1:0]       m_used_count,
    output logic                              m_last_of_run
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    localparam int KW  = nket_pkg::KEY_W;
    localparam int NW  = nket_pkg::NUM_W;
    localparam int SW  = nket_pkg::SLOT_W;
    localparam int UW  = nket_pkg::USED_W;

    // input latches
    logic [KW-1:0] key_reg;
    logic [NW-1:0] num_reg;

    // read pipeline
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pend_idx_reg, pend_idx_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // pending result of a single-result command
    nket_pkg::status_t res_status_reg;
    logic [SW-1:0]     res_slot_reg;

    // result register
    logic              out_valid_reg;
    logic [nket_pkg::STATUS_W-1:0] out_status_reg;
    logic [SW-1:0]     out_slot_reg;
    logic [KW-1:0]     out_name_reg;
    logic [NW-1:0]     out_num_reg;
    logic [UW-1:0]     out_used_reg;
    logic              out_last_reg;

    // ram ports
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [KW-1:0]    name_rd;
    logic [NW-1:0]    num_rd;
    logic             name_we, num_we;
    logic [IDX_W-1:0] name_waddr, num_waddr;
    logic [KW-1:0]    name_wdata;
    logic [NW-1:0]    num_wdata;

    logic             can_issue;
    logic             issue;
    logic [CNT_W-1:0] shift_dst;
    logic [CNT_W+SW-1:0] pend_slot_ext, count_slot_ext;
    logic [CNT_W+UW-1:0] used_ext;
    logic [SW-1:0]    pend_slot, count_slot, res_slot_sel;
    logic [UW-1:0]    used_now;

    assign can_issue = (idx_reg < count_reg);
    assign issue     = (cmd.step && can_issue) || cmd.list_read;

    assign pend_slot_ext  = {{SW{1'b0}}, pend_idx_reg};
    assign count_slot_ext = {{SW{1'b0}}, count_reg};
    assign used_ext       = {{UW{1'b0}}, count_reg};
    assign pend_slot      = pend_slot_ext[SW-1:0];
    assign count_slot     = count_slot_ext[SW-1:0];
    assign used_now       = used_ext[UW-1:0];

    always_comb begin
        case (cmd.res_slot)
            nket_pkg::SLOT_HIT:   res_slot_sel = pend_slot;
            nket_pkg::SLOT_COUNT: res_slot_sel = count_slot;
            default:              res_slot_sel = '0;
        endcase
    end

    // pipeline and count next state
    always_comb begin
        idx_next      = idx_reg;
        pend_idx_next = pend_idx_reg;
        pend_next     = pend_reg;
        count_next    = count_reg;
        if (cmd.load_in) begin
            idx_next  = '0;
            pend_next = 1'b0;
        end else if (cmd.shift_init) begin
            idx_next  = pend_idx_reg + 1'b1;
            pend_next = 1'b0;
        end else if (issue) begin
            idx_next      = idx_reg + 1'b1;
            pend_idx_next = idx_reg;
            pend_next     = 1'b1;
        end else if (cmd.step) begin
            pend_next = 1'b0;
        end
        if (cmd.append) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.dec_count) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign rd_en     = issue;
    assign rd_addr   = idx_reg[IDX_W-1:0];
    assign shift_dst = pend_idx_reg - 1'b1;

    // name and number stores: written by append and by the shift, the number also by an update
    always_comb begin
        name_we    = 1'b0;
        name_waddr = count_reg[IDX_W-1:0];
        name_wdata = key_reg;
        num_we     = 1'b0;
        num_waddr  = count_reg[IDX_W-1:0];
        num_wdata  = num_reg;
        if (cmd.append) begin
            name_we = 1'b1;
            num_we  = 1'b1;
        end else if (cmd.upd_number) begin
            num_we    = 1'b1;
            num_waddr = pend_idx_reg[IDX_W-1:0];
        end else if (cmd.shift && pend_reg) begin
            name_we    = 1'b1;
            num_we     = 1'b1;
            name_waddr = shift_dst[IDX_W-1:0];
            num_waddr  = shift_dst[IDX_W-1:0];
            name_wdata = name_rd;
            num_wdata  = num_rd;
        end
    end

    nket_ram #(
        .WIDTH (KW),
        .DEPTH (TABLE_DEPTH)
    ) u_name_ram (
        .aclk  (aclk),
        .we    (name_we),
        .waddr (name_waddr),
        .wdata (name_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (name_rd)
    );

    nket_ram #(
        .WIDTH (NW),
        .DEPTH (TABLE_DEPTH)
    ) u_number_ram (
        .aclk  (aclk),
        .we    (num_we),
        .waddr (num_waddr),
        .wdata (num_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (num_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            if (cmd.emit_res || cmd.emit_entry) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        if (cmd.load_in) begin
            key_reg <= {s_key_word_a, s_key_word_b, s_key_word_c};
            num_reg <= {s_number_word_a, s_number_word_b};
        end
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= res_slot_sel;
        end
        if (cmd.emit_res) begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_name_reg   <= '0;
            out_num_reg    <= '0;
            out_used_reg   <= used_now;
            out_last_reg   <= 1'b1;
        end else if (cmd.emit_entry) begin
            out_status_reg <= nket_pkg::ST_LISTED;
            out_slot_reg   <= pend_slot;
            out_name_reg   <= name_rd;
            out_num_reg    <= num_rd;
            out_used_reg   <= used_now;
            out_last_reg   <= sts.list_last;
        end
    end

    assign sts.hit        = pend_reg && (name_rd == key_reg);
    assign sts.miss       = !pend_reg && !can_issue;
    assign sts.full       = (count_reg == DEPTH_C);
    assign sts.empty      = (count_reg == '0);
    assign sts.shift_done = !pend_reg && !can_issue;
    // idx has already moved past the entry held in the read register
    assign sts.list_last  = !can_issue || (32'(idx_reg) >= nket_pkg::LIST_LIMIT);
    assign sts.out_free   = !out_valid_reg || m_ready;

    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_slot         = out_slot_reg;
    assign m_out_name_a   = out_name_reg[KW-1 -: nket_pkg::KEY_A_W];
    assign m_out_name_b   = out_name_reg[nket_pkg::KEY_B_W+nket_pkg::KEY_C_W-1 -:
                                         nket_pkg::KEY_B_W];
    assign m_out_name_c   = out_name_reg[nket_pkg::KEY_C_W-1:0];
    assign m_out_number_a = out_num_reg[NW-1 -: nket_pkg::NUM_A_W];
    assign m_out_number_b = out_num_reg[nket_pkg::NUM_B_W-1:0];
    assign m_used_count   = out_used_reg;
    assign m_last_of_run  = out_last_reg;

endmodule

>>> rtl/nket_ctrl.sv
// ----------------------------------------------------------------------------
// nket_ctrl
// Command sequencer: search, update, append, remove with shift-down, and
// listing, driving the datapath through command bundles.
// ----------------------------------------------------------------------------
module nket_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [nket_pkg::KIND_W-1:0]   s_kind,
    input  nket_pkg::sts_t                sts,
    output nket_pkg::cmd_t                cmd
);

    typedef enum logic [2:0] {
        IDLE,
        SEARCH,
        SHIFT,
        RESP,
        LIST_RD,
        LIST_OUT
    } state_t;

    state_t          state_reg, state_next;
    nket_pkg::kind_t kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            kind_reg  <= nket_pkg::KIND_ADD;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.res_status = nket_pkg::ST_EMPTY;
        cmd.res_slot   = nket_pkg::SLOT_NONE;
        case (state_reg)
            IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    kind_next   = nket_pkg::kind_t'(s_kind);
                    case (s_kind)
                        nket_pkg::KIND_ADD,
                        nket_pkg::KIND_REMOVE: state_next = SEARCH;
                        nket_pkg::KIND_LIST: begin
                            if (sts.empty) begin
                                cmd.set_res    = 1'b1;
                                cmd.res_status = nket_pkg::ST_EMPTY;
                                state_next     = RESP;
                            end else begin
                                state_next = LIST_RD;
                            end
                        end
                        // unused kind: dropped without a result
                        default: state_next = IDLE;
                    endcase
                end
            end
            SEARCH: begin
                if (sts.hit) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_slot = nket_pkg::SLOT_HIT;
                    if (kind_reg == nket_pkg::KIND_ADD) begin
                        cmd.upd_number = 1'b1;
                        cmd.res_status = nket_pkg::ST_UPDATED;
                        state_next     = RESP;
                    end else begin
                        cmd.shift_init = 1'b1;
                        cmd.res_status = nket_pkg::ST_REMOVED;
                        state_next     = SHIFT;
                    end
                end else if (sts.miss) begin
                    cmd.set_res = 1'b1;
                    state_next  = RESP;
                    if (kind_reg == nket_pkg::KIND_ADD) begin
                        if (sts.full) begin
                            cmd.res_status = nket_pkg::ST_FULL;
                        end else begin
                            cmd.append     = 1'b1;
                            cmd.res_status = nket_pkg::ST_ADDED;
                            cmd.res_slot   = nket_pkg::SLOT_COUNT;
                        end
                    end else begin
                        cmd.res_status = nket_pkg::ST_NOT_FOUND;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            SHIFT: begin
                cmd.step  = 1'b1;
                cmd.shift = 1'b1;
                if (sts.shift_done) begin
                    cmd.dec_count = 1'b1;
                    state_next    = RESP;
                end
            end
            RESP: begin
                if (sts.out_free) begin
                    cmd.emit_res = 1'b1;
                    state_next   = IDLE;
                end
            end
            LIST_RD: begin
                cmd.list_read = 1'b1;
                state_next    = LIST_OUT;
            end
            LIST_OUT: begin
                if (sts.out_free) begin
                    cmd.emit_entry = 1'b1;
                    state_next     = sts.list_last ? IDLE : LIST_RD;
                end
            end
            default: state_next = IDLE;
        endcase
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the name keyed entry table. A clocked driver offers
// commands from a queue, and a clocked monitor predicts the reports of each
// accepted command with its own copy of the entry table. It compares every
// report field by field. The stimulus starts with directed commands: empty,
// full, updates, removal with shift-down and near-equal keys. Random phases
// follow, with varied idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import nket_pkg::*;

    localparam int DEPTH = 16;
    localparam int POOL_SIZE = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [NUM_W-1:0]  number;
    } entry_cmd_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_A_W-1:0]  name_a;
        logic [KEY_B_W-1:0]  name_b;
        logic [KEY_C_W-1:0]  name_c;
        logic [NUM_A_W-1:0]  number_a;
        logic [NUM_B_W-1:0]  number_b;
        logic [USED_W-1:0]   used;
        logic                last;
    } entry_report_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind = '0;
    logic [KEY_A_W-1:0]  s_key_word_a = '0;
    logic [KEY_B_W-1:0]  s_key_word_b = '0;
    logic [KEY_C_W-1:0]  s_key_word_c = '0;
    logic [NUM_A_W-1:0]  s_number_word_a = '0;
    logic [NUM_B_W-1:0]  s_number_word_b = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [SLOT_W-1:0]   m_slot;
    logic [KEY_A_W-1:0]  m_out_name_a;
    logic [KEY_B_W-1:0]  m_out_name_b;
    logic [KEY_C_W-1:0]  m_out_name_c;
    logic [NUM_A_W-1:0]  m_out_number_a;
    logic [NUM_B_W-1:0]  m_out_number_b;
    logic [USED_W-1:0]   m_used_count;
    logic                m_last_of_run;

    name_keyed_entry_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_key_word_a   (s_key_word_a),
        .s_key_word_b   (s_key_word_b),
        .s_key_word_c   (s_key_word_c),
        .s_number_word_a(s_number_word_a),
        .s_number_word_b(s_number_word_b),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot         (m_slot),
        .m_out_name_a   (m_out_name_a),
        .m_out_name_b   (m_out_name_b),
        .m_out_name_c   (m_out_name_c),
        .m_out_number_a (m_out_number_a),
        .m_out_number_b (m_out_number_b),
        .m_used_count   (m_used_count),
        .m_last_of_run  (m_last_of_run)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 0;
    end

    // predicted contents of the entry table
    logic [KEY_W-1:0] entry_names [DEPTH];
    logic [NUM_W-1:0] entry_numbers [DEPTH];
    int               entry_total = 0;

    entry_cmd_t       command_queue [$];
    entry_report_t    pending_reports [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 1'b0;
    bit  hold_ack = 1'b0;
    int  hold_left = 0;
    bit  s_taken = 1'b0;
    int  fail_count = 0;
    int  commands_taken = 0;
    int  results_checked = 0;
    int  full_reports = 0;
    int  highest_fill = 0;
    int  cycle_count = 0;

    function automatic void note_report(status_t st, int slot, int pos, bit last);
        entry_report_t r;
        r = '0;
        r.status = st;
        r.slot = slot[SLOT_W-1:0];
        if (pos >= 0) begin
            {r.name_a, r.name_b, r.name_c} = entry_names[pos];
            {r.number_a, r.number_b} = entry_numbers[pos];
        end
        r.used = entry_total[USED_W-1:0];
        r.last = last;
        pending_reports.push_back(r);
    endfunction

    function automatic void apply_command(entry_cmd_t c);
        int hit;
        int shown;
        hit = -1;
        for (int i = 0; i < entry_total; i++)
            if (hit < 0 && entry_names[i] == c.key)
                hit = i;
        case (c.kind)
            KIND_ADD: begin
                if (hit >= 0) begin
                    entry_numbers[hit] = c.number;
                    note_report(ST_UPDATED, hit, -1, 1'b1);
                end else if (entry_total < DEPTH) begin
                    entry_names[entry_total] = c.key;
                    entry_numbers[entry_total] = c.number;
                    entry_total++;
                    note_report(ST_ADDED, entry_total - 1, -1, 1'b1);
                end else begin
                    full_reports++;
                    note_report(ST_FULL, 0, -1, 1'b1);
                end
                if (entry_total > highest_fill)
                    highest_fill = entry_total;
            end
            KIND_REMOVE: begin
                if (hit < 0) begin
                    note_report(ST_NOT_FOUND, 0, -1, 1'b1);
                end else begin
                    // close the gap so the table stays packed
                    for (int i = hit; i + 1 < entry_total; i++) begin
                        entry_names[i] = entry_names[i + 1];
                        entry_numbers[i] = entry_numbers[i + 1];
                    end
                    entry_total--;
                    note_report(ST_REMOVED, hit, -1, 1'b1);
                end
            end
            KIND_LIST: begin
                shown = (entry_total > LIST_LIMIT) ? LIST_LIMIT : entry_total;
                if (shown == 0)
                    note_report(ST_EMPTY, 0, -1, 1'b1);
                for (int i = 0; i < shown; i++)
                    note_report(ST_LISTED, i, i, i + 1 == shown);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string field, logic [63:0] expv, logic [63:0] actv);
        if (expv !== actv) begin
            fail_count++;
            $error("tb: %s mismatch, expected %0h, got %0h", field, expv, actv);
        end
    endfunction

    function automatic void push_cmd(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                     logic [NUM_W-1:0] number);
        entry_cmd_t c;
        c.kind = kind;
        c.key = key;
        c.number = number;
        command_queue.push_back(c);
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        return KEY_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    endfunction

    function automatic logic [NUM_W-1:0] random_number();
        return {$urandom, $urandom, $urandom};
    endfunction

    function automatic void push_random_cmd(int add_pct);
        int r;
        logic [KEY_W-1:0] key;
        r = $urandom_range(99);
        if ($urandom_range(19) == 0)
            key = random_key();
        else
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
        if (r < add_pct)
            push_cmd(KIND_ADD, key, random_number());
        else if (r < add_pct + 25)
            push_cmd(KIND_REMOVE, key, random_number());
        else if (r < 97)
            push_cmd(KIND_LIST, key, random_number());
        else
            push_cmd(KIND_UNUSED, key, random_number());
    endfunction

    // sender: offer the next command once the current one is transferred
    always @(negedge aclk) begin
        entry_cmd_t c;
        if (!s_valid || s_taken) begin
            if (command_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                c = command_queue.pop_front();
                s_valid <= 1'b1;
                s_kind <= c.kind;
                {s_key_word_a, s_key_word_b, s_key_word_c} <= c.key;
                {s_number_word_a, s_number_word_b} <= c.number;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        entry_cmd_t c;
        entry_report_t e;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_reports.size() == 0) begin
                fail_count++;
                $error("tb: report transfer with none expected, status %0d", m_status);
            end else begin
                e = pending_reports.pop_front();
                check_field("status", e.status, m_status);
                check_field("slot", e.slot, m_slot);
                check_field("out_name_a", e.name_a, m_out_name_a);
                check_field("out_name_b", e.name_b, m_out_name_b);
                check_field("out_name_c", e.name_c, m_out_name_c);
                check_field("out_number_a", e.number_a, m_out_number_a);
                check_field("out_number_b", e.number_b, m_out_number_b);
                check_field("used_count", e.used, m_used_count);
                check_field("last_of_run", e.last, m_last_of_run);
            end
        end
        if (aresetn && s_valid && s_ready) begin
            c.kind = s_kind;
            c.key = {s_key_word_a, s_key_word_b, s_key_word_c};
            c.number = {s_number_word_a, s_number_word_b};
            commands_taken++;
            apply_command(c);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(negedge aclk);
        while (command_queue.size() != 0 || s_valid || pending_reports.size() != 0);
        @(posedge aclk);
    endtask

    initial begin
        logic [KEY_W-1:0] ones_key;
        logic [KEY_W-1:0] gap_key;
        logic [KEY_W-1:0] gap_twin;
        logic [KEY_W-1:0] pad_mask;
        int               pos;

        for (int k = 0; k < POOL_SIZE; k++) begin
            key_pool[k] = random_key();
            // names with an inner zero byte, short padded names, near twins
            if (k % 3 == 0) begin
                pos = $urandom_range(17, 1);
                key_pool[k][KEY_W-1-8*pos -: 8] = 8'h00;
            end
            if (k % 4 == 2) begin
                pos = $urandom_range(18, 1);
                pad_mask = {KEY_W{1'b1}} << (8 * (19 - pos));
                key_pool[k] = key_pool[k] & pad_mask;
            end
            if (k % 5 == 1)
                key_pool[k] = {key_pool[k-1][KEY_W-1:8], key_pool[k][7:0] ^ 8'h5a};
        end
        ones_key = {KEY_W{1'b1}};
        gap_key = random_key();
        gap_key[KEY_W-1-24 -: 8] = 8'h00;
        // twin differs only in a byte past the zero byte
        gap_twin = gap_key ^ ({{(KEY_W-1){1'b0}}, 1'b1} << 48);

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // directed part
        push_cmd(KIND_LIST, random_key(), random_number());
        push_cmd(KIND_REMOVE, ones_key, '0);
        push_cmd(KIND_UNUSED, random_key(), random_number());
        push_cmd(KIND_ADD, ones_key, {NUM_W{1'b1}});
        push_cmd(KIND_ADD, '0, '0);
        push_cmd(KIND_ADD, gap_key, random_number());
        push_cmd(KIND_ADD, gap_twin, random_number());
        push_cmd(KIND_ADD, ones_key, random_number());
        push_cmd(KIND_LIST, '0, '0);
        push_cmd(KIND_REMOVE, '0, random_number());
        for (int k = 0; k < 13; k++)
            push_cmd(KIND_ADD, key_pool[k], random_number());
        push_cmd(KIND_ADD, key_pool[13], random_number());
        push_cmd(KIND_LIST, ones_key, '0);
        push_cmd(KIND_REMOVE, key_pool[12], '0);
        push_cmd(KIND_REMOVE, ones_key, '0);
        wait_drained();

        // random phases: no idling, sender idle, receiver stall with hold-off,
        // both idle, then add-heavy with no idling
        for (int ph = 0; ph < 5; ph++) begin
            send_idle_pct = (ph == 1) ? 57 : (ph == 3) ? 35 : 0;
            recv_stall_pct = (ph == 2) ? 57 : (ph == 3) ? 35 : 0;
            if (ph == 2)
                hold_req = ~hold_req;
            for (int n = 0; n < 25; n++)
                push_random_cmd((ph == 4) ? 70 : 45);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("tb: %0d commands transferred, %0d reports checked",
                 commands_taken, results_checked);
        $display("tb: %0d table-full reports, highest fill %0d of %0d",
                 full_reports, highest_fill, DEPTH);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
